/* rtl/core/assert_macros.svh */
// Assertion helpers for the RTL files, used by hsl_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check an implication that may reach into later cycles.
`define ASSERT_SEQ(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

/* rtl/core/hsl_pkg.sv */
`default_nettype none

package hsl_pkg;

	// Datapath widths
	localparam int CH_W  = 8;   // channel byte
	localparam int QP_W  = 16;  // q, p and q-p in units of 1/65025
	localparam int POS_W = 14;  // hue position in units of 1/12288 turn
	localparam int WT_W  = 12;  // ramp weight, 0..2048

	// Hue positions, units of 1/12288 turn
	localparam logic [POS_W-1:0] TURN       = 14'd12288;
	localparam logic [POS_W-1:0] THIRD      = 14'd4096;
	localparam logic [POS_W-1:0] SIXTH      = 14'd2048;
	localparam logic [POS_W-1:0] HALF       = 14'd6144;
	localparam logic [POS_W-1:0] TWO_THIRDS = 14'd8192;

	// Per-stage load strobes from the pipeline control
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} hsl_load_t;

endpackage

`default_nettype wire

/* rtl/core/hsl_ctrl.sv */
`default_nettype none

`include "assert_macros.svh"

module hsl_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output hsl_pkg::hsl_load_t     load
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	// A stage takes a new item when it is empty or its item moves on
	assign rdy5 = !vld_s5 || out_ready;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	assign in_ready  = rdy1;
	assign out_valid = vld_s5;

	assign load.s1 = rdy1 && in_valid;
	assign load.s2 = rdy2 && vld_s1;
	assign load.s3 = rdy3 && vld_s2;
	assign load.s4 = rdy4 && vld_s3;
	assign load.s5 = rdy5 && vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	`ASSERT_ALWAYS(a_empty_s1_ready, clk, arst_n, !vld_s1 -> in_ready, "stage 1 empty but input stalled")
	`ASSERT_SEQ(a_accept_fills_s1, clk, arst_n, (in_valid && in_ready) |=> vld_s1, "accepted item lost at stage 1")
	`ASSERT_SEQ(a_drain_empty, clk, arst_n, (out_valid && out_ready && !vld_s4) |=> !out_valid, "result repeated after delivery")

endmodule

`default_nettype wire

/* rtl/core/hsl_front.sv */
`default_nettype none

module hsl_front (
	input  wire logic                          clk,
	input  wire hsl_pkg::hsl_load_t            load,
	input  wire logic [11:0]                   hue,
	input  wire logic [hsl_pkg::CH_W-1:0]      saturation,
	input  wire logic [hsl_pkg::CH_W-1:0]      lightness,
	output logic      [hsl_pkg::QP_W-1:0]      p,
	output logic      [hsl_pkg::QP_W-1:0]      d,
	output logic      [hsl_pkg::WT_W-1:0]      x_red,
	output logic      [hsl_pkg::WT_W-1:0]      x_green,
	output logic      [hsl_pkg::WT_W-1:0]      x_blue
);

	// Ramp weight: rising over the first sixth, flat to one half,
	// falling to two thirds, zero beyond.
	function automatic logic [hsl_pkg::WT_W-1:0] ramp_weight(
		input logic [hsl_pkg::POS_W-1:0] tt
	);
		logic [hsl_pkg::POS_W-1:0] fall;
		fall = hsl_pkg::TWO_THIRDS - tt;
		if (tt < hsl_pkg::SIXTH)
			return tt[hsl_pkg::WT_W-1:0];
		else if (tt < hsl_pkg::HALF)
			return hsl_pkg::SIXTH[hsl_pkg::WT_W-1:0];
		else if (tt < hsl_pkg::TWO_THIRDS)
			return fall[hsl_pkg::WT_W-1:0];
		else
			return '0;
	endfunction

	logic [15:0] ls, l255, s255;
	logic [16:0] q_lo, q_hi;
	logic [15:0] q_c;
	logic [13:0] h3, t_r, t_b;
	logic [14:0] t_r_raw;
	logic [16:0] l510, p_c;

	logic [15:0] q_s1;
	logic [7:0]  l_s1;
	logic [13:0] t_r_s1, t_g_s1, t_b_s1;

	// Stage 1: q and the three hue positions
	assign ls   = {8'b0, lightness} * {8'b0, saturation};
	assign l255 = {lightness, 8'b0} - {8'b0, lightness};
	assign s255 = {saturation, 8'b0} - {8'b0, saturation};
	assign q_lo = {1'b0, l255} + {1'b0, ls};
	assign q_hi = {1'b0, l255} + {1'b0, s255} - {1'b0, ls};
	assign q_c  = lightness[7] ? q_hi[15:0] : q_lo[15:0];

	assign h3      = {1'b0, hue, 1'b0} + {2'b0, hue};
	assign t_r_raw = {1'b0, h3} + {1'b0, hsl_pkg::THIRD};
	// Wrap only above a full turn; exactly one turn stays and reads as p
	assign t_r = (t_r_raw > {1'b0, hsl_pkg::TURN}) ?
		14'(t_r_raw - {1'b0, hsl_pkg::TURN}) : t_r_raw[13:0];
	assign t_b = (h3 < hsl_pkg::THIRD) ? (h3 + hsl_pkg::TWO_THIRDS) : (h3 - hsl_pkg::THIRD);

	always_ff @(posedge clk) begin
		if (load.s1) begin
			q_s1   <= q_c;
			l_s1   <= lightness;
			t_r_s1 <= t_r;
			t_g_s1 <= h3;
			t_b_s1 <= t_b;
		end
	end

	// Stage 2: p = 2L - q, slope q - p, ramp weights
	assign l510 = {l_s1, 9'b0} - {8'b0, l_s1, 1'b0};
	assign p_c  = l510 - {1'b0, q_s1};

	always_ff @(posedge clk) begin
		if (load.s2) begin
			p       <= p_c[15:0];
			d       <= q_s1 - p_c[15:0];
			x_red   <= ramp_weight(t_r_s1);
			x_green <= ramp_weight(t_g_s1);
			x_blue  <= ramp_weight(t_b_s1);
		end
	end

endmodule

`default_nettype wire

/* rtl/core/hsl_chan.sv */
`default_nettype none

module hsl_chan (
	input  wire logic                          clk,
	input  wire hsl_pkg::hsl_load_t            load,
	input  wire logic [hsl_pkg::QP_W-1:0]      p,
	input  wire logic [hsl_pkg::QP_W-1:0]      d,
	input  wire logic [hsl_pkg::WT_W-1:0]      x,
	output logic      [hsl_pkg::CH_W-1:0]      level
);

	logic [27:0] prod_s3;
	logic [15:0] p_s3;
	logic [15:0] v_s4;
	logic [27:0] num;
	logic [16:0] quo_sum;
	logic [8:0]  quo;

	// Stage 3: slope times weight
	always_ff @(posedge clk) begin
		if (load.s3) begin
			prod_s3 <= {12'b0, d} * {16'b0, x};
			p_s3    <= p;
		end
	end

	// Stage 4: ramp value in 1/65025 units (drop the 1/2048 weight scale)
	assign num = {1'b0, p_s3, 11'b0} + prod_s3;

	always_ff @(posedge clk) begin
		if (load.s4) v_s4 <= num[26:11];
	end

	// Stage 5: floor divide by 255, exact for values up to 65279
	// (the ramp value never exceeds 65025)
	assign quo_sum = {1'b0, v_s4} + 17'd1 + {9'b0, v_s4[15:8]};
	assign quo     = quo_sum[16:8];

	always_ff @(posedge clk) begin
		if (load.s5) level <= quo[8] ? 8'hFF : quo[7:0];
	end

endmodule

`default_nettype wire

/* rtl/core/hsl_to_rgb.sv */
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  hsl     | hsl_valid / hsl_ready | hue[11:0] saturation lightness alpha_in
//  rgb     | rgb_valid / rgb_ready | red green blue alpha_out
//
//  Five register stages; an accepted pixel passes stages 1 to 5 in order to reach rgb.
//  One pixel enters per cycle unless rgb stalls and the stages fill up; the rate is set by the stage handshake alone.
//  Reset clears only the stage valid bits; data registers start undefined.
//  Each stage holds its item while the next is full and stalled, so a stall on rgb backs
//  up one stage at a time and bubbles are squeezed out before hsl stalls.
`default_nettype none

module hsl_to_rgb (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        hsl_valid,
	output logic             hsl_ready,
	input  wire logic [11:0] hue,
	input  wire logic [7:0]  saturation,
	input  wire logic [7:0]  lightness,
	input  wire logic [7:0]  alpha_in,
	output logic             rgb_valid,
	input  wire logic        rgb_ready,
	output logic      [7:0]  red,
	output logic      [7:0]  green,
	output logic      [7:0]  blue,
	output logic      [7:0]  alpha_out
);

	hsl_pkg::hsl_load_t load;

	logic [hsl_pkg::QP_W-1:0] p_s2, d_s2;
	logic [hsl_pkg::WT_W-1:0] x_red_s2, x_green_s2, x_blue_s2;

	logic [7:0] alpha_s1, alpha_s2, alpha_s3, alpha_s4;

	// Valid bits and per-stage load strobes
	hsl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hsl_valid),
		.in_ready  (hsl_ready),
		.out_valid (rgb_valid),
		.out_ready (rgb_ready),
		.load      (load)
	);

	// Stages 1-2: q, p and the ramp weights of the three hue positions.
	// Zero saturation needs no special path: q = p = 255*L there, the
	// slope is zero and every channel comes out as lightness.
	hsl_front u_front (
		.clk        (clk),
		.load       (load),
		.hue        (hue),
		.saturation (saturation),
		.lightness  (lightness),
		.p          (p_s2),
		.d          (d_s2),
		.x_red      (x_red_s2),
		.x_green    (x_green_s2),
		.x_blue     (x_blue_s2)
	);

	// Stages 3-5: one ramp evaluation and byte conversion per channel
	hsl_chan u_red (
		.clk   (clk),
		.load  (load),
		.p     (p_s2),
		.d     (d_s2),
		.x     (x_red_s2),
		.level (red)
	);

	hsl_chan u_green (
		.clk   (clk),
		.load  (load),
		.p     (p_s2),
		.d     (d_s2),
		.x     (x_green_s2),
		.level (green)
	);

	hsl_chan u_blue (
		.clk   (clk),
		.load  (load),
		.p     (p_s2),
		.d     (d_s2),
		.x     (x_blue_s2),
		.level (blue)
	);

	// Carry alpha alongside the color math
	always_ff @(posedge clk) begin
		if (load.s1) alpha_s1  <= alpha_in;
		if (load.s2) alpha_s2  <= alpha_s1;
		if (load.s3) alpha_s3  <= alpha_s2;
		if (load.s4) alpha_s4  <= alpha_s3;
		if (load.s5) alpha_out <= alpha_s4;
	end

endmodule

`default_nettype wire
